### design/altf_pkg.sv
`default_nettype none

package altf_pkg;

   localparam int WORD_W      = 16;
   localparam int LEN_W       = 18;
   localparam int HDR_W       = 4;
   localparam int BLOCK_WORDS = 16;
   localparam int IDX_W       = $clog2(BLOCK_WORDS);
   localparam int FILL_W      = IDX_W + 1;

   localparam logic [HDR_W-1:0]  HDR_WORDS = 4'd8;
   localparam logic [WORD_W-1:0] START_BIT = 16'h8000;

   // tape word select
   localparam logic [2:0] SEL_ZERO      = 3'd0;
   localparam logic [2:0] SEL_NEG_COUNT = 3'd1;
   localparam logic [2:0] SEL_ADDR      = 3'd2;
   localparam logic [2:0] SEL_BLOCK_CK  = 3'd3;
   localparam logic [2:0] SEL_DATA      = 3'd4;
   localparam logic [2:0] SEL_ONE       = 3'd5;
   localparam logic [2:0] SEL_START     = 3'd6;
   localparam logic [2:0] SEL_START_CK  = 3'd7;

   typedef struct packed {
      logic       accept;
      logic [2:0] sel;
      logic       idx_reset;
      logic       idx_step;
      logic       clear_block;
      logic       set_finished;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hdr_last;
      logic data_ev;
      logic length_zero;
      logic run_done;
      logic block_full;
      logic data_last;
      logic finished;
   } dp_status_type;

endpackage

`default_nettype wire

### design/absolute_loader_tape_framer_top.sv
`default_nettype none

// loader tape framer: object file words in, loader tape words out
// input: one object word per item on req_in_word, taken when start is high and busy low
// results: rsp_out_word with rsp_last_of_run and rsp_end_of_output, valid while
//   rsp_strobe is high, one word per cycle; the receiver cannot stall, so none is held
// config: csr_wr_en writes csr_suppress_start; user writes only while idle, not enforced
// an item's results follow the decode state S_DECIDE that comes after every taken item;
//   an item with no result goes from S_DECIDE back to idle
// an item that closes a block of n data words gives the negative count, load address,
//   block checksum, n data words and two zero words, and after the last data word
//   the start block: a one, the start word and its checksum
// a full 16-word block is 16 items: the first 15 give no result, the last closes it
// after the start block every further item is taken and dropped with no result
// reset clears the header count, length, counters, the config flag and the finished flag;
//   the block buffer is not cleared, each entry is written before it is read

module absolute_loader_tape_framer_top
   import altf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [WORD_W-1:0] req_in_word,
   output logic                   rsp_strobe,
   output logic [WORD_W-1:0]      rsp_out_word,
   output logic                   rsp_last_of_run,
   output logic                   rsp_end_of_output,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_suppress_start
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   altf_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .status            (status),
      .cmd               (cmd),
      .busy              (busy),
      .rsp_strobe        (rsp_strobe),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_output (rsp_end_of_output)
   );

   altf_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_suppress_start (csr_suppress_start),
      .req_in_word        (req_in_word),
      .cmd                (cmd),
      .status             (status),
      .rsp_out_word       (rsp_out_word)
   );

endmodule

`default_nettype wire

### design/altf_dpath.sv
`default_nettype none

module altf_dpath
   import altf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_suppress_start,
   input  wire logic [WORD_W-1:0] req_in_word,
   input  wire ctrl_cmd_type      cmd,
   output dp_status_type          status,
   output logic [WORD_W-1:0]      rsp_out_word
);

   localparam logic [HDR_W-1:0] HDR_LEN_A = 4'd1;
   localparam logic [HDR_W-1:0] HDR_LEN_B = 4'd2;
   localparam logic [HDR_W-1:0] HDR_LEN_C = 4'd6;

   logic                suppress_ff;
   logic [HDR_W-1:0]    hdr_idx_ff,  hdr_idx_in;
   logic [LEN_W-1:0]    length_ff,   length_in;
   logic [LEN_W-1:0]    taken_ff,    taken_in;
   logic [FILL_W-1:0]   fill_ff,     fill_in;
   logic [WORD_W-1:0]   sum_ff,      sum_in;
   logic                finished_ff, finished_in;
   logic                hdr_last_ff, hdr_last_in;
   logic                data_ev_ff,  data_ev_in;
   logic [IDX_W-1:0]    idx_ff,      idx_in;
   logic [WORD_W-1:0]   rd_data_ff;
   logic [WORD_W-1:0]   mem [BLOCK_WORDS];

   logic                take_word;
   logic                take_data;
   logic [IDX_W-1:0]    rd_addr;
   logic [WORD_W-1:0]   fill_word;
   logic [WORD_W-1:0]   neg_count;
   logic [WORD_W-1:0]   load_addr;
   logic [WORD_W-1:0]   block_ck;
   logic [WORD_W-1:0]   start_word;
   logic [WORD_W-1:0]   start_ck;

   assign take_word = cmd.accept && !finished_ff;
   assign take_data = take_word && (hdr_idx_ff == HDR_WORDS);
   assign rd_addr   = cmd.idx_reset ? '0 : idx_ff + 1'b1;

   always_comb begin
      hdr_idx_in  = hdr_idx_ff;
      length_in   = length_ff;
      taken_in    = taken_ff;
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      finished_in = finished_ff;
      hdr_last_in = hdr_last_ff;
      data_ev_in  = data_ev_ff;
      idx_in      = idx_ff;
      if (cmd.accept) begin
         hdr_last_in = 1'b0;
         data_ev_in  = 1'b0;
      end
      if (take_word) begin
         if (hdr_idx_ff != HDR_WORDS) begin
            if (hdr_idx_ff inside {HDR_LEN_A, HDR_LEN_B, HDR_LEN_C}) begin
               length_in = length_ff + {{(LEN_W-WORD_W){1'b0}}, req_in_word};
            end
            hdr_idx_in  = hdr_idx_ff + 1'b1;
            hdr_last_in = (hdr_idx_ff == HDR_WORDS - 1'b1);
         end else begin
            fill_in    = fill_ff + 1'b1;
            sum_in     = sum_ff + req_in_word;
            taken_in   = taken_ff + 1'b1;
            data_ev_in = 1'b1;
         end
      end
      if (cmd.clear_block) begin
         fill_in = '0;
         sum_in  = '0;
      end
      if (cmd.set_finished) begin
         finished_in = 1'b1;
      end
      if (cmd.idx_reset) begin
         idx_in = '0;
      end else if (cmd.idx_step) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         suppress_ff <= 1'b0;
         hdr_idx_ff  <= '0;
         length_ff   <= '0;
         taken_ff    <= '0;
         fill_ff     <= '0;
         sum_ff      <= '0;
         finished_ff <= 1'b0;
         hdr_last_ff <= 1'b0;
         data_ev_ff  <= 1'b0;
         idx_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            suppress_ff <= csr_suppress_start;
         end
         hdr_idx_ff  <= hdr_idx_in;
         length_ff   <= length_in;
         taken_ff    <= taken_in;
         fill_ff     <= fill_in;
         sum_ff      <= sum_in;
         finished_ff <= finished_in;
         hdr_last_ff <= hdr_last_in;
         data_ev_ff  <= data_ev_in;
         idx_ff      <= idx_in;
      end
   end

   // block buffer
   always_ff @(posedge clock) begin
      if (take_data) begin
         mem[fill_ff[IDX_W-1:0]] <= req_in_word;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign fill_word  = {{(WORD_W-FILL_W){1'b0}}, fill_ff};
   assign neg_count  = '0 - fill_word;
   assign load_addr  = taken_ff[WORD_W-1:0] - fill_word;
   assign block_ck   = '0 - (neg_count + load_addr + sum_ff);
   assign start_word = suppress_ff ? '0 : START_BIT;
   assign start_ck   = '0 - (start_word + 1'b1);

   always_comb begin
      case (cmd.sel)
         SEL_ZERO:      rsp_out_word = '0;
         SEL_NEG_COUNT: rsp_out_word = neg_count;
         SEL_ADDR:      rsp_out_word = load_addr;
         SEL_BLOCK_CK:  rsp_out_word = block_ck;
         SEL_DATA:      rsp_out_word = rd_data_ff;
         SEL_ONE:       rsp_out_word = {{(WORD_W-1){1'b0}}, 1'b1};
         SEL_START:     rsp_out_word = start_word;
         SEL_START_CK:  rsp_out_word = start_ck;
         default:       rsp_out_word = '0;
      endcase
   end

   assign status.hdr_last    = hdr_last_ff;
   assign status.data_ev     = data_ev_ff;
   assign status.length_zero = (length_ff == '0);
   assign status.run_done    = (taken_ff >= length_ff);
   assign status.block_full  = (fill_ff == FILL_W'(BLOCK_WORDS));
   assign status.data_last   = (({1'b0, idx_ff} + 1'b1) == fill_ff);
   assign status.finished    = finished_ff;

endmodule

`default_nettype wire

### design/altf_ctrl.sv
`default_nettype none

module altf_ctrl
   import altf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd,
   output logic               busy,
   output logic               rsp_strobe,
   output logic               rsp_last_of_run,
   output logic               rsp_end_of_output
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECIDE   = 4'd1;
   localparam logic [3:0] S_HDR_Z0   = 4'd2;
   localparam logic [3:0] S_HDR_Z1   = 4'd3;
   localparam logic [3:0] S_BLK_NEG  = 4'd4;
   localparam logic [3:0] S_BLK_ADDR = 4'd5;
   localparam logic [3:0] S_BLK_CK   = 4'd6;
   localparam logic [3:0] S_BLK_DATA = 4'd7;
   localparam logic [3:0] S_BLK_Z0   = 4'd8;
   localparam logic [3:0] S_BLK_Z1   = 4'd9;
   localparam logic [3:0] S_ST_ONE   = 4'd10;
   localparam logic [3:0] S_ST_WORD  = 4'd11;
   localparam logic [3:0] S_ST_CK    = 4'd12;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in          = state_ff;
      cmd               = '0;
      cmd.sel           = SEL_ZERO;
      rsp_strobe        = 1'b0;
      rsp_last_of_run   = 1'b0;
      rsp_end_of_output = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.hdr_last) begin
               state_in = S_HDR_Z0;
            end else if (status.data_ev && (status.block_full || status.run_done)) begin
               state_in = S_BLK_NEG;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_HDR_Z0: begin
            rsp_strobe = 1'b1;
            state_in   = S_HDR_Z1;
         end
         S_HDR_Z1: begin
            rsp_strobe = 1'b1;
            if (status.length_zero) begin
               state_in = S_ST_ONE;
            end else begin
               rsp_last_of_run = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_BLK_NEG: begin
            rsp_strobe = 1'b1;
            cmd.sel    = SEL_NEG_COUNT;
            state_in   = S_BLK_ADDR;
         end
         S_BLK_ADDR: begin
            rsp_strobe = 1'b1;
            cmd.sel    = SEL_ADDR;
            state_in   = S_BLK_CK;
         end
         S_BLK_CK: begin
            rsp_strobe    = 1'b1;
            cmd.sel       = SEL_BLOCK_CK;
            cmd.idx_reset = 1'b1;
            state_in      = S_BLK_DATA;
         end
         S_BLK_DATA: begin
            rsp_strobe   = 1'b1;
            cmd.sel      = SEL_DATA;
            cmd.idx_step = 1'b1;
            if (status.data_last) begin
               state_in = S_BLK_Z0;
            end
         end
         S_BLK_Z0: begin
            rsp_strobe = 1'b1;
            state_in   = S_BLK_Z1;
         end
         S_BLK_Z1: begin
            rsp_strobe      = 1'b1;
            cmd.clear_block = 1'b1;
            if (status.run_done) begin
               state_in = S_ST_ONE;
            end else begin
               rsp_last_of_run = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_ST_ONE: begin
            rsp_strobe = 1'b1;
            cmd.sel    = SEL_ONE;
            state_in   = S_ST_WORD;
         end
         S_ST_WORD: begin
            rsp_strobe = 1'b1;
            cmd.sel    = SEL_START;
            state_in   = S_ST_CK;
         end
         S_ST_CK: begin
            rsp_strobe        = 1'b1;
            rsp_last_of_run   = 1'b1;
            rsp_end_of_output = 1'b1;
            cmd.sel           = SEL_START_CK;
            cmd.set_finished  = 1'b1;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_eoo_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_end_of_output |-> (rsp_last_of_run && rsp_strobe))
      else $error("end of output without last of run");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_run |=> !rsp_strobe)
      else $error("result right after last of run");

   a_finished_after_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ST_CK) |=> status.finished)
      else $error("start block out but not finished");

   a_start_block_cause: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ST_ONE) |-> (status.run_done || status.length_zero))
      else $error("start block before end of data");

   a_block_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BLK_NEG) |-> !(status.data_last && status.block_full))
      else $error("block count inconsistent");
`endif

endmodule

`default_nettype wire
